@@ rtl/packed_epaper_to_bgr_pixels_unit_assert.svh @@
`ifndef PACKED_EPAPER_TO_BGR_PIXELS_UNIT_ASSERT_SVH
`define PACKED_EPAPER_TO_BGR_PIXELS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PEPBGR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pepbgr assertion failed");

// next-cycle implication, checked outside reset
`define PEPBGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pepbgr assertion failed");

`endif

@@ rtl/pepbgr_pkg.sv @@
`default_nettype none

package pepbgr_pkg;

    localparam int CFG_DW = 13;
    localparam int CFG_IW = 2;
    localparam int FMT_W  = 4;

    localparam logic [CFG_IW-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd1;

    localparam logic [FMT_W-1:0] FMT_MONO      = 4'd0;
    localparam logic [FMT_W-1:0] FMT_DUAL_RED  = 4'd1;
    localparam logic [FMT_W-1:0] FMT_DUAL_YEL  = 4'd2;
    localparam logic [FMT_W-1:0] FMT_GRAY2     = 4'd3;
    localparam logic [FMT_W-1:0] FMT_BWYR      = 4'd4;
    localparam logic [FMT_W-1:0] FMT_SEVEN     = 4'd5;
    localparam logic [FMT_W-1:0] FMT_SPECTRA6  = 4'd6;
    localparam logic [FMT_W-1:0] FMT_GRAY4     = 4'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic              we;
        logic [CFG_IW-1:0] index;
        logic [CFG_DW-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]       pb;
        logic [7:0]       ab;
        logic [FMT_W-1:0] fmt;
        logic [2:0]       last_k;
        logic             row_end;
        logic [1:0]       pad;
    } t_job;

    localparam t_rgb PAL4 [4] = '{
        '{8'd57,  8'd48,  8'd57},
        '{8'd255, 8'd255, 8'd255},
        '{8'd208, 8'd190, 8'd71},
        '{8'd156, 8'd72,  8'd75}
    };

    localparam t_rgb PAL7 [7] = '{
        '{8'd57,  8'd48,  8'd57},
        '{8'd255, 8'd255, 8'd255},
        '{8'd58,  8'd91,  8'd70},
        '{8'd61,  8'd59,  8'd94},
        '{8'd156, 8'd72,  8'd75},
        '{8'd208, 8'd190, 8'd71},
        '{8'd177, 8'd106, 8'd73}
    };

    localparam t_rgb PALSP6 [7] = '{
        '{8'd25,  8'd20,  8'd38},
        '{8'd178, 8'd193, 8'd192},
        '{8'd199, 8'd187, 8'd0},
        '{8'd107, 8'd17,  8'd25},
        '{8'd255, 8'd255, 8'd255},
        '{8'd24,  8'd83,  8'd154},
        '{8'd42,  8'd85,  8'd49}
    };

    function automatic t_rgb gray(input logic [7:0] v);
        t_rgb c;
        c.r = v;
        c.g = v;
        c.b = v;
        return c;
    endfunction

    function automatic t_rgb pixel_color(
        input logic [FMT_W-1:0] fmt,
        input logic [7:0]       pb,
        input logic [7:0]       ab,
        input logic [2:0]       k
    );
        logic [7:0] pb_bit_sh;
        logic [7:0] ab_bit_sh;
        logic [7:0] two_sh;
        logic [1:0] two;
        logic [3:0] nib;
        logic [2:0] pidx;
        t_rgb       c;
        pb_bit_sh = pb << k;
        ab_bit_sh = ab << k;
        two_sh    = pb << {k[1:0], 1'b0};
        two       = two_sh[7:6];
        nib       = k[0] ? pb[3:0] : pb[7:4];
        pidx      = (nib >= 4'd7) ? 3'd1 : nib[2:0];
        case (fmt)
            FMT_MONO: begin
                c = gray(pb_bit_sh[7] ? 8'd255 : 8'd0);
            end
            FMT_DUAL_RED, FMT_DUAL_YEL: begin
                if (!pb_bit_sh[7]) begin
                    c = gray(8'd0);
                end else if (!ab_bit_sh[7]) begin
                    c.r = 8'd255;
                    c.g = (fmt == FMT_DUAL_RED) ? 8'd0 : 8'd255;
                    c.b = 8'd0;
                end else begin
                    c = gray(8'd255);
                end
            end
            FMT_GRAY2:    c = gray({two, two, two, two});
            FMT_BWYR:     c = PAL4[two];
            FMT_SEVEN:    c = PAL7[pidx];
            FMT_SPECTRA6: c = PALSP6[pidx];
            FMT_GRAY4:    c = gray({nib, nib});
            default:      c = gray(8'd255);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pepbgr_front.sv @@
`default_nettype none

module pepbgr_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pepbgr_pkg::t_cfg_wr i_cfg,
    input  wire logic                i_push,
    input  wire logic                i_full,
    input  wire logic [7:0]          i_packed_byte,
    input  wire logic [7:0]          i_accent_byte,
    output logic                     o_q_push,
    output pepbgr_pkg::t_job         o_q_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > pepbgr_pkg::CFG_DW) ? WW : pepbgr_pkg::CFG_DW;

    logic [pepbgr_pkg::FMT_W-1:0]  r_fmt;
    logic [pepbgr_pkg::CFG_DW-1:0] r_width;
    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 n_col;

    logic [XW-1:0] w_ext;
    logic [WW-1:0] w_eff;
    logic [CW-1:0] col0;
    logic [WW-1:0] remaining;
    logic [3:0]    per_byte;
    logic          row_end;
    logic          accept;

    assign accept = i_push && !i_full;
    assign w_ext  = XW'(r_width);

    always_comb begin
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_ext);
        end
    end

    always_comb begin
        case (r_fmt) inside
            pepbgr_pkg::FMT_GRAY2, pepbgr_pkg::FMT_BWYR:         per_byte = 4'd4;
            [pepbgr_pkg::FMT_SEVEN : pepbgr_pkg::FMT_GRAY4]:     per_byte = 4'd2;
            default:                                             per_byte = 4'd8;
        endcase
    end

    always_comb begin
        col0      = (WW'(r_col) >= w_eff) ? '0 : r_col;
        remaining = w_eff - WW'(col0);
        row_end   = remaining <= WW'(per_byte);
        n_col     = row_end ? '0 : col0 + CW'(per_byte);
    end

    always_comb begin
        o_q_push        = accept;
        o_q_job.pb      = i_packed_byte;
        o_q_job.ab      = i_accent_byte;
        o_q_job.fmt     = r_fmt;
        o_q_job.last_k  = row_end ? 3'(remaining - WW'(1)) : 3'(per_byte - 4'd1);
        o_q_job.row_end = row_end;
        o_q_job.pad     = w_eff[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= pepbgr_pkg::FMT_MONO;
            r_width <= pepbgr_pkg::CFG_DW'(1);
            r_col   <= '0;
        end else begin
            if (i_cfg.we && i_cfg.index == pepbgr_pkg::CFG_PIXEL_FORMAT) begin
                r_fmt <= i_cfg.data[pepbgr_pkg::FMT_W-1:0];
            end
            if (i_cfg.we && i_cfg.index == pepbgr_pkg::CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg.data;
            end
            if (accept) begin
                r_col <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pepbgr_queue.sv @@
`default_nettype none

module pepbgr_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pepbgr_pkg::t_job i_job,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output pepbgr_pkg::t_job      o_job
);

    pepbgr_pkg::t_job r_mem [pepbgr_pkg::QUEUE_DEPTH];

    logic [pepbgr_pkg::QPW-1:0] r_wr_ptr;
    logic [pepbgr_pkg::QPW-1:0] r_rd_ptr;
    logic [pepbgr_pkg::QCW-1:0] r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = r_count == pepbgr_pkg::QCW'(pepbgr_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == pepbgr_pkg::QPW'(pepbgr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == pepbgr_pkg::QPW'(pepbgr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/pepbgr_back.sv @@
`default_nettype none

module pepbgr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire pepbgr_pkg::t_job i_q_job,
    output logic                  o_q_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_green,
    output logic [7:0]            o_red,
    output logic                  o_row_done,
    output logic [1:0]            o_pad_count,
    output logic                  o_run_last
);

    logic [2:0]        r_k;
    logic              r_out_valid;
    pepbgr_pkg::t_rgb  r_rgb;
    logic              r_row_done;
    logic [1:0]        r_pad;
    logic              r_run_last;

    logic              load;
    logic              last;
    pepbgr_pkg::t_rgb  color;

    assign load    = i_q_valid && (!r_out_valid || i_pop);
    assign last    = r_k == i_q_job.last_k;
    assign o_q_pop = load && last;
    assign color   = pepbgr_pkg::pixel_color(i_q_job.fmt, i_q_job.pb, i_q_job.ab, r_k);

    // hold the pixel until it is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rgb      <= color;
            r_row_done <= last && i_q_job.row_end;
            r_pad      <= (last && i_q_job.row_end) ? i_q_job.pad : 2'd0;
            r_run_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k <= last ? 3'd0 : r_k + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_blue      = r_rgb.b;
    assign o_green     = r_rgb.g;
    assign o_red       = r_rgb.r;
    assign o_row_done  = r_row_done;
    assign o_pad_count = r_pad;
    assign o_run_last  = r_run_last;

endmodule

`default_nettype wire

@@ rtl/packed_epaper_to_bgr_pixels_unit.sv @@
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+----------------------------------------
// bytes in  | input     | push / full                 | i_packed_byte, i_accent_byte
// pixels    | output    | empty / pop                 | o_blue, o_green, o_red, o_row_done,
//           |           |                             | o_pad_count, o_run_last
// config    | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One pixel leaves per cycle while pop is high and bytes wait; a byte yields as many pixels
// as its format packs: 8 for one-bit formats, 4 for two-bit, 2 for four-bit, fewer at a row end.
// The back stage holds each pixel in its single output register.
// Reset is synchronous: it clears the column, the queue and the output valid, and sets mono, width 1.
// With pop low the output holds; after two waiting bytes full rises.
`default_nettype none

`include "packed_epaper_to_bgr_pixels_unit_assert.svh"

module packed_epaper_to_bgr_pixels_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pepbgr_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [pepbgr_pkg::CFG_DW-1:0]     i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_packed_byte,
    input  wire logic [7:0]                        i_accent_byte,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [7:0]                             o_blue,
    output logic [7:0]                             o_green,
    output logic [7:0]                             o_red,
    output logic                                   o_row_done,
    output logic [1:0]                             o_pad_count,
    output logic                                   o_run_last
);

    pepbgr_pkg::t_cfg_wr cfg;
    pepbgr_pkg::t_job    front_job;
    pepbgr_pkg::t_job    q_job;
    logic                front_push;
    logic                q_valid;
    logic                q_pop;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    pepbgr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_full        (full),
        .i_packed_byte (i_packed_byte),
        .i_accent_byte (i_accent_byte),
        .o_q_push      (front_push),
        .o_q_job       (front_job)
    );

    pepbgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    pepbgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_blue      (o_blue),
        .o_green     (o_green),
        .o_red       (o_red),
        .o_row_done  (o_row_done),
        .o_pad_count (o_pad_count),
        .o_run_last  (o_run_last)
    );

    `PEPBGR_ASSERT_NOW(a_row_done_ends_run, !empty && o_row_done, o_run_last)
    `PEPBGR_ASSERT_NOW(a_pad_only_at_row_end, !empty && !o_row_done, o_pad_count == 2'd0)
    `PEPBGR_ASSERT_NOW(a_full_has_job, full, q_valid)
    `PEPBGR_ASSERT_NEXT(a_job_gives_pixel, q_valid && (empty || pop), !empty)

endmodule

`default_nettype wire
